// ===== hw/rtl/aqd_pkg.sv =====
package aqd_pkg;

  // Field widths
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int STEPS_W         = 16;
  localparam int THR_W           = 12;
  localparam int OP_W            = 2;
  localparam int DIR_W           = 2;
  localparam int TOTAL_W         = 8;
  localparam int WHOLE_W         = 17;
  localparam int MICRO_W         = 21;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // Serial divider geometry
  localparam int PROD_W  = 16;  // |pulses| * 360 <= 46080
  localparam int QUO_W   = 20;  // micro quotient < 1000000
  localparam int DVD_W   = 36;  // remainder * 1000000 < 2**36
  localparam int CNT_W   = 6;
  localparam int SCALE_W = 20;

  localparam logic [CNT_W-1:0]   WHOLE_STEPS = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0]   MICRO_STEPS = CNT_W'(DVD_W);
  localparam logic [8:0]         DEG_PER_TURN = 9'd360;
  localparam logic [SCALE_W-1:0] MICRO_SCALE  = SCALE_W'(1000000);

  // Register reset values and indexes
  localparam logic [STEPS_W-1:0]   STEPS_RST = STEPS_W'(24);
  localparam logic [THR_W-1:0]     THR_RST   = THR_W'(128);
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THR   = CFG_IDX_W'(1);

  // Phase bits: A is the upper bit, B the lower
  localparam logic [1:0] PHASE_A = 2'b10;
  localparam logic [1:0] PHASE_B = 2'b01;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_OTHER  = 2'd2
  } op_t;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_UNSUP = 1'b1
  } status_t;

  // Gray-code step from {old phase, new phase}
  function automatic logic signed [DIR_W-1:0] decode_step(input logic [3:0] code);
    logic signed [DIR_W-1:0] s;
    case (code)
      4'd2, 4'd4, 4'd13, 4'd11: s = -2'sd1;
      4'd1, 4'd7, 4'd14, 4'd8:  s = 2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/aqd_in_if.sv =====
interface aqd_in_if #(
  parameter int SAMPLE_BITS = aqd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [aqd_pkg::OP_W-1:0]      operation;
  logic [SAMPLE_BITS-1:0]        sample_a;
  logic [SAMPLE_BITS-1:0]        sample_b;

  modport source (output valid, output operation, output sample_a, output sample_b,
                  input ready);
  modport sink   (input valid, input operation, input sample_a, input sample_b,
                  output ready);
endinterface

// ===== hw/rtl/aqd_out_if.sv =====
interface aqd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [aqd_pkg::DIR_W-1:0]    direction;
  logic                                notify;
  logic signed [aqd_pkg::TOTAL_W-1:0]  pulse_total;
  logic signed [aqd_pkg::WHOLE_W-1:0]  whole_degrees;
  logic signed [aqd_pkg::MICRO_W-1:0]  micro_degrees;

  modport source (output valid, output status, output direction, output notify,
                  output pulse_total, output whole_degrees, output micro_degrees,
                  input ready);
  modport sink   (input valid, input status, input direction, input notify,
                  input pulse_total, input whole_degrees, input micro_degrees,
                  output ready);
endinterface

// ===== hw/rtl/aqd_cfg_if.sv =====
interface aqd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [aqd_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [aqd_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/analog_quadrature_decoder_core.sv =====
// Channel   Dir  Type        Payload
// in_ch     in   aqd_in_if   operation, sample_a, sample_b
// out_ch    out  aqd_out_if  status, direction, notify, pulse_total,
//                            whole_degrees, micro_degrees
// cfg_ch    in   aqd_cfg_if  reg_index (0 steps_per_turn, 1 delta_threshold), wdata
//
// A sample pair or an unsupported read finishes in the cycle it is accepted:
// its result is registered at that edge.
// A rotation read runs restoring division for whole degrees, a multiply step
// that scales the remainder, restoring division for millionths and a load of
// the output register once it is free. The shared bit-serial divider produces
// one quotient bit per cycle.
// One transaction is in flight at a time; in_ch.ready is low while a read
// runs and while an untaken result blocks the output register.
// rst_n is synchronous and active low; it clears the decoder state and loads
// steps_per_turn = 24, delta_threshold = 128. cfg_ch is always ready.
module analog_quadrature_decoder_core #(
  parameter int SAMPLE_BITS = aqd_pkg::SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  aqd_in_if.sink          in_ch,
  aqd_out_if.source       out_ch,
  aqd_cfg_if.sink         cfg_ch
);

  // Width of the signed sample change, wide enough for both the change
  // and the negated threshold.
  localparam int DW = ((SAMPLE_BITS > aqd_pkg::THR_W) ? SAMPLE_BITS : aqd_pkg::THR_W) + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // wait for a transaction
    S_DIVW = 5'b00010,  // divide |pulses|*360 by steps (by 1 if steps is 0)
    S_MUL  = 5'b00100,  // scale the remainder by one million
    S_DIVM = 5'b01000,  // divide the scaled remainder by the same divisor
    S_FIN  = 5'b10000   // load the read result once the output is free
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [aqd_pkg::STEPS_W-1:0] steps_r, steps_nxt;
  logic [aqd_pkg::THR_W-1:0]   thr_r, thr_nxt;

  // Decoder state
  logic [SAMPLE_BITS-1:0]      last_a_r, last_a_nxt;
  logic [SAMPLE_BITS-1:0]      last_b_r, last_b_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic [aqd_pkg::TOTAL_W-1:0] pulse_r, pulse_nxt;

  // Divider datapath
  logic [aqd_pkg::DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [aqd_pkg::STEPS_W-1:0] rem_r, rem_nxt;
  logic [aqd_pkg::STEPS_W-1:0] div_r, div_nxt;
  logic [aqd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        neg_r, neg_nxt;
  logic [aqd_pkg::PROD_W-1:0]  whole_mag_r, whole_mag_nxt;
  logic [aqd_pkg::TOTAL_W-1:0] hold_total_r, hold_total_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_status_r, out_status_nxt;
  logic signed [aqd_pkg::DIR_W-1:0]   out_dir_r, out_dir_nxt;
  logic                               out_notify_r, out_notify_nxt;
  logic [aqd_pkg::TOTAL_W-1:0]        out_total_r, out_total_nxt;
  logic [aqd_pkg::WHOLE_W-1:0]        out_whole_r, out_whole_nxt;
  logic [aqd_pkg::MICRO_W-1:0]        out_micro_r, out_micro_nxt;

  logic out_free, in_ready, in_acc;

  // Sample-pair decode
  logic signed [DW-1:0]         da, db, th, nth;
  logic [1:0]                   phase_new;
  logic signed [aqd_pkg::DIR_W-1:0] step;
  logic [aqd_pkg::TOTAL_W-1:0]  pulse_sum;

  // Read setup
  logic [aqd_pkg::TOTAL_W-1:0]  p_mag;
  logic [aqd_pkg::PROD_W-1:0]   prod_mag;

  // Divider step
  logic [aqd_pkg::STEPS_W:0]    trial;
  logic                         ge;
  logic [aqd_pkg::STEPS_W-1:0]  rem_step;
  logic [aqd_pkg::DVD_W-1:0]    dvd_step;
  logic [aqd_pkg::DVD_W-1:0]    scaled;

  // Result signs
  logic [aqd_pkg::WHOLE_W-1:0]  whole_ext;
  logic [aqd_pkg::MICRO_W-1:0]  micro_ext;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.direction     = out_dir_r;
  assign out_ch.notify        = out_notify_r;
  assign out_ch.pulse_total   = out_total_r;
  assign out_ch.whole_degrees = out_whole_r;
  assign out_ch.micro_degrees = out_micro_r;

  // Phase update: a rise beyond the threshold sets the bit, a fall clears it.
  always_comb begin
    da  = $signed({{(DW-SAMPLE_BITS){1'b0}}, in_ch.sample_a})
        - $signed({{(DW-SAMPLE_BITS){1'b0}}, last_a_r});
    db  = $signed({{(DW-SAMPLE_BITS){1'b0}}, in_ch.sample_b})
        - $signed({{(DW-SAMPLE_BITS){1'b0}}, last_b_r});
    th  = $signed({{(DW-aqd_pkg::THR_W){1'b0}}, thr_r});
    nth = -th;
    phase_new = phase_r;
    if (da > th)  phase_new = phase_new | aqd_pkg::PHASE_A;
    if (da < nth) phase_new = phase_new & ~aqd_pkg::PHASE_A;
    if (db > th)  phase_new = phase_new | aqd_pkg::PHASE_B;
    if (db < nth) phase_new = phase_new & ~aqd_pkg::PHASE_B;
    // An unchanged phase decodes to no step in the table.
    step      = aqd_pkg::decode_step({phase_r, phase_new});
    pulse_sum = pulse_r + {{(aqd_pkg::TOTAL_W-aqd_pkg::DIR_W){step[1]}}, step};
  end

  // Read setup: magnitude of the count times 360 (360 = 256 + 64 + 32 + 8).
  always_comb begin
    p_mag    = pulse_r[aqd_pkg::TOTAL_W-1] ? (~pulse_r + 1'b1) : pulse_r;
    prod_mag = aqd_pkg::PROD_W'({8'd0, p_mag} * {7'd0, aqd_pkg::DEG_PER_TURN});
  end

  // One restoring-division step: shift in the dividend MSB, subtract if it fits.
  always_comb begin
    trial    = {rem_r, dvd_r[aqd_pkg::DVD_W-1]};
    ge       = trial >= {1'b0, div_r};
    rem_step = ge ? aqd_pkg::STEPS_W'(trial - {1'b0, div_r})
                  : trial[aqd_pkg::STEPS_W-1:0];
    dvd_step = {dvd_r[aqd_pkg::DVD_W-2:0], ge};
    scaled   = {{(aqd_pkg::DVD_W-aqd_pkg::STEPS_W){1'b0}}, rem_r}
             * {{(aqd_pkg::DVD_W-aqd_pkg::SCALE_W){1'b0}}, aqd_pkg::MICRO_SCALE};
    whole_ext = {1'b0, whole_mag_r};
    micro_ext = {1'b0, dvd_r[aqd_pkg::QUO_W-1:0]};
  end

  always_comb begin
    state_nxt      = state_r;
    steps_nxt      = steps_r;
    thr_nxt        = thr_r;
    last_a_nxt     = last_a_r;
    last_b_nxt     = last_b_r;
    phase_nxt      = phase_r;
    pulse_nxt      = pulse_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    whole_mag_nxt  = whole_mag_r;
    hold_total_nxt = hold_total_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_dir_nxt    = out_dir_r;
    out_notify_nxt = out_notify_r;
    out_total_nxt  = out_total_r;
    out_whole_nxt  = out_whole_r;
    out_micro_nxt  = out_micro_r;

    // Drop the result once taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        aqd_pkg::REG_STEPS: steps_nxt = cfg_ch.wdata[aqd_pkg::STEPS_W-1:0];
        aqd_pkg::REG_THR:   thr_nxt   = cfg_ch.wdata[aqd_pkg::THR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.operation)
            aqd_pkg::OP_SAMPLE: begin
              last_a_nxt     = in_ch.sample_a;
              last_b_nxt     = in_ch.sample_b;
              phase_nxt      = phase_new;
              pulse_nxt      = pulse_sum;
              out_valid_nxt  = 1'b1;
              out_status_nxt = aqd_pkg::ST_OK;
              out_dir_nxt    = step;
              out_notify_nxt = (step != 2'sd0);
              out_total_nxt  = pulse_sum;
              out_whole_nxt  = '0;
              out_micro_nxt  = '0;
            end
            aqd_pkg::OP_READ: begin
              // Start the whole-degree division; clear the count now.
              neg_nxt        = pulse_r[aqd_pkg::TOTAL_W-1];
              hold_total_nxt = pulse_r;
              pulse_nxt      = '0;
              div_nxt        = (steps_r == '0) ? aqd_pkg::STEPS_W'(1) : steps_r;
              dvd_nxt        = {prod_mag, {(aqd_pkg::DVD_W-aqd_pkg::PROD_W){1'b0}}};
              rem_nxt        = '0;
              cnt_nxt        = aqd_pkg::WHOLE_STEPS;
              state_nxt      = S_DIVW;
            end
            default: begin
              // Any other channel: report the count, keep it.
              out_valid_nxt  = 1'b1;
              out_status_nxt = aqd_pkg::ST_UNSUP;
              out_dir_nxt    = 2'sd0;
              out_notify_nxt = 1'b0;
              out_total_nxt  = pulse_r;
              out_whole_nxt  = '0;
              out_micro_nxt  = '0;
            end
          endcase
        end
      end
      S_DIVW: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == aqd_pkg::CNT_W'(1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Quotient sits in the low bits; the remainder gets scaled.
        whole_mag_nxt = dvd_r[aqd_pkg::PROD_W-1:0];
        dvd_nxt       = scaled;
        rem_nxt       = '0;
        cnt_nxt       = aqd_pkg::MICRO_STEPS;
        state_nxt     = S_DIVM;
      end
      S_DIVM: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == aqd_pkg::CNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          // Apply the sign of the count to both parts (truncation toward zero).
          out_valid_nxt  = 1'b1;
          out_status_nxt = aqd_pkg::ST_OK;
          out_dir_nxt    = 2'sd0;
          out_notify_nxt = 1'b0;
          out_total_nxt  = hold_total_r;
          out_whole_nxt  = neg_r ? (~whole_ext + 1'b1) : whole_ext;
          out_micro_nxt  = neg_r ? (~micro_ext + 1'b1) : micro_ext;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steps_r     <= aqd_pkg::STEPS_RST;
      thr_r       <= aqd_pkg::THR_RST;
      last_a_r    <= '0;
      last_b_r    <= '0;
      phase_r     <= '0;
      pulse_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      steps_r     <= steps_nxt;
      thr_r       <= thr_nxt;
      last_a_r    <= last_a_nxt;
      last_b_r    <= last_b_nxt;
      phase_r     <= phase_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    whole_mag_r  <= whole_mag_nxt;
    hold_total_r <= hold_total_nxt;
    out_status_r <= out_status_nxt;
    out_dir_r    <= out_dir_nxt;
    out_notify_r <= out_notify_nxt;
    out_total_r  <= out_total_nxt;
    out_whole_r  <= out_whole_nxt;
    out_micro_r  <= out_micro_nxt;
  end

  // A rotation read starts the divider and clears the count at once.
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == aqd_pkg::OP_READ)
      |=> (state_r == S_DIVW && pulse_r == '0))
    else $error("rotation read did not start division or clear count");

  // The partial remainder stays below the divisor throughout the micro pass.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVM) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // Sample pairs and other-channel reads give a valid result in the next cycle, with the block idle.
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation != aqd_pkg::OP_READ) |=> (out_valid_r && state_r == S_IDLE))
    else $error("single-cycle transaction did not produce a result");

  // The last micro step always hands over to the output load.
  a_divm_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVM && cnt_r == aqd_pkg::CNT_W'(1)) |=> (state_r == S_FIN))
    else $error("micro division did not finish");

endmodule

// ===== bench/analog_quadrature_decoder_core_tb.sv =====
module analog_quadrature_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = aqd_pkg::SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'(SAMPLE_MAX);
  localparam logic [SAMPLE_W-1:0] SAMPLE_LOW = '0;
  localparam int RAIL_BAND  = 400;       // how close to a rail a steered edge lands
  localparam int TURN_DEGREES = 360;
  localparam longint MILLIONTHS = 1000000;
  localparam logic [aqd_pkg::STEPS_W-1:0] STEPS_AFTER_RESET  = 16'd24;
  localparam logic [aqd_pkg::THR_W-1:0]   THRESH_AFTER_RESET = 12'd128;
  localparam logic [aqd_pkg::OP_W-1:0]    OP_SPARE = 2'd3;   // unused code, other channel
  localparam logic [aqd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [aqd_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 64;      // idle wait before the final verdict

  typedef struct {
    logic                                 status;
    logic signed [aqd_pkg::DIR_W-1:0]     direction;
    logic                                 notify;
    logic signed [aqd_pkg::TOTAL_W-1:0]   pulse_total;
    logic signed [aqd_pkg::WHOLE_W-1:0]   whole_degrees;
    logic signed [aqd_pkg::MICRO_W-1:0]   micro_degrees;
  } decoder_result_t;

  logic clk;
  logic rst_n;

  aqd_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_bus ();
  aqd_out_if out_bus ();
  aqd_cfg_if cfg_bus ();

  analog_quadrature_decoder_core #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Decoder state as the testbench tracks it, updated at each accepted transaction
  logic [SAMPLE_W-1:0]          prev_a, prev_b;
  logic [1:0]                   phase_q;
  logic [aqd_pkg::TOTAL_W-1:0]  count_q;
  logic [aqd_pkg::STEPS_W-1:0]  steps_q;
  logic [aqd_pkg::THR_W-1:0]    thresh_q;

  decoder_result_t pending_results[$];

  int  mismatch_count = 0;
  int  result_index = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;    // receiver hold-off request, consumed by the ready process
  bit  no_idle = 1'b0;     // both sides run without gaps while set
  int  spin_dir = 1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: expected result of one accepted transaction; advances the state
  // ---------------------------------------------------------------------------
  function automatic decoder_result_t predict_decoder_result(
      input logic [aqd_pkg::OP_W-1:0] op,
      input logic [SAMPLE_W-1:0] a,
      input logic [SAMPLE_W-1:0] b);
    decoder_result_t r;
    int da, db, th, pulse_step, pulses, divisor, prod, rem;
    longint frac;
    logic [1:0] nw, pos_old, pos_new;
    r = '{default: '0};
    r.status = aqd_pkg::ST_OK;
    if (op == aqd_pkg::OP_SAMPLE) begin
      da = int'(a) - int'(prev_a);
      db = int'(b) - int'(prev_b);
      th = int'(thresh_q);
      nw = phase_q;
      // a swing beyond the threshold sets or clears that channel's phase bit
      if (da > th)  nw = nw | aqd_pkg::PHASE_A;
      if (da < -th) nw = nw & ~aqd_pkg::PHASE_A;
      if (db > th)  nw = nw | aqd_pkg::PHASE_B;
      if (db < -th) nw = nw & ~aqd_pkg::PHASE_B;
      prev_a = a;
      prev_b = b;
      pulse_step = 0;
      if (nw != phase_q) begin
        // map the Gray phase to a position around the cycle; a two-bit jump is no step
        pos_old = {phase_q[1], ^phase_q};
        pos_new = {nw[1], ^nw};
        case (2'(pos_new - pos_old))
          2'd1:    pulse_step = 1;
          2'd3:    pulse_step = -1;
          default: pulse_step = 0;
        endcase
      end
      phase_q = nw;
      if (pulse_step != 0) begin
        count_q = count_q + aqd_pkg::TOTAL_W'(pulse_step);
        r.notify = 1'b1;
      end
      r.direction = aqd_pkg::DIR_W'(pulse_step);
      r.pulse_total = count_q;
    end else if (op == aqd_pkg::OP_READ) begin
      pulses = int'($signed(count_q));
      divisor = (steps_q == '0) ? 1 : int'(steps_q);
      prod = pulses * TURN_DEGREES;
      rem = prod % divisor;
      r.pulse_total = count_q;
      r.whole_degrees = aqd_pkg::WHOLE_W'(prod / divisor);
      frac = longint'(rem) * MILLIONTHS / longint'(divisor);
      r.micro_degrees = aqd_pkg::MICRO_W'(frac);
      count_q = '0;
    end else begin
      r.status = aqd_pkg::ST_UNSUP;
      r.pulse_total = count_q;
    end
    return r;
  endfunction

  // Pick a sample that moves one channel toward the wanted phase bit
  function automatic logic [SAMPLE_W-1:0] steer_sample(input logic [SAMPLE_W-1:0] last,
                                                        input logic now_high,
                                                        input logic want_high);
    int th, cur, jit, lo, hi;
    th = int'(thresh_q);
    cur = int'(last);
    if (want_high && !now_high) begin
      if (cur + th + 1 > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
      lo = cur + th + 1;
      if (lo < SAMPLE_MAX - RAIL_BAND) lo = SAMPLE_MAX - RAIL_BAND;
      return SAMPLE_W'($urandom_range(SAMPLE_MAX, lo));
    end
    if (!want_high && now_high) begin
      if (cur - th - 1 < 0) return '0;
      hi = cur - th - 1;
      if (hi > RAIL_BAND) hi = RAIL_BAND;
      return SAMPLE_W'($urandom_range(hi, 0));
    end
    // hold: jitter inside the threshold so the bit stays put
    jit = (th < 64) ? th : 64;
    lo = (cur - jit < 0) ? 0 : cur - jit;
    hi = (cur + jit > SAMPLE_MAX) ? SAMPLE_MAX : cur + jit;
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one transaction; predict it at the edge it is accepted
  task automatic send_item(input logic [aqd_pkg::OP_W-1:0] op,
                           input logic [SAMPLE_W-1:0] a,
                           input logic [SAMPLE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.sample_a  <= a;
    in_bus.sample_b  <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_results.push_back(predict_decoder_result(op, a, b));
  endtask

  // Drop valid so nothing more is offered
  task automatic release_bus();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  // Pause the sender until every expected result has come back
  task automatic wait_drain();
    release_bus();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aqd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aqd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    if (idx == aqd_pkg::REG_STEPS) steps_q = data;
    else if (idx == aqd_pkg::REG_THR) thresh_q = data[aqd_pkg::THR_W-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Idle the block, then load both registers; junk goes to the upper threshold
  // bits and to one of the unused indexes
  task automatic configure(input int steps, input int thr);
    wait_drain();
    write_reg(aqd_pkg::REG_STEPS, aqd_pkg::CFG_DATA_W'(steps));
    write_reg(aqd_pkg::REG_THR, {4'($urandom_range(15)), aqd_pkg::THR_W'(thr)});
    if ($urandom_range(1)) write_reg(REG_UNUSED_LO, aqd_pkg::CFG_DATA_W'($urandom));
    else write_reg(REG_UNUSED_HI, aqd_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic send_toward(input logic [1:0] target);
    send_item(aqd_pkg::OP_SAMPLE, steer_sample(prev_a, phase_q[1], target[1]),
              steer_sample(prev_b, phase_q[0], target[0]));
  endtask

  // One quadrature step forward (+1) or backward (-1)
  task automatic send_step(input int dir);
    logic [1:0] pos;
    pos = {phase_q[1], ^phase_q} + 2'(dir);
    send_toward({pos[1], ^pos});
  endtask

  task automatic send_read();
    send_item(aqd_pkg::OP_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready with short and long stalls, plus hold-off requests
  // ---------------------------------------------------------------------------
  initial begin
    int run, r;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
      end else if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 65) begin
          out_bus.ready <= 1'b1;
          run = $urandom_range(12, 1);
        end else begin
          out_bus.ready <= 1'b0;
          r = $urandom_range(99);
          if (r < 80) run = $urandom_range(3, 1);
          else if (r < 97) run = $urandom_range(12, 4);
          else run = $urandom_range(60, 20);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, result_index, what,
             got, want);
    mismatch_count++;
  endtask

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    decoder_result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, pulse_total", out_bus.pulse_total, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.status !== want.status)
          report_mismatch("status", out_bus.status, want.status);
        if (out_bus.direction !== want.direction)
          report_mismatch("direction", out_bus.direction, want.direction);
        if (out_bus.notify !== want.notify)
          report_mismatch("notify", out_bus.notify, want.notify);
        if (out_bus.pulse_total !== want.pulse_total)
          report_mismatch("pulse_total", out_bus.pulse_total, want.pulse_total);
        if (out_bus.whole_degrees !== want.whole_degrees)
          report_mismatch("whole_degrees", out_bus.whole_degrees, want.whole_degrees);
        if (out_bus.micro_degrees !== want.micro_degrees)
          report_mismatch("micro_degrees", out_bus.micro_degrees, want.micro_degrees);
      end
      result_index++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read straight out of reset: zero total, zero degrees
  task automatic test_reset_read();
    send_read();
  endtask

  // Full forward cycle 00-01-11-10-00 on rail-to-rail samples, then read 60 degrees
  task automatic test_forward_turn();
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_TOP);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_TOP, SAMPLE_LOW);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_LOW);
    send_read();
  endtask

  // Full backward cycle, read -60 degrees
  task automatic test_backward_turn();
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_TOP, SAMPLE_LOW);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_TOP);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_LOW);
    send_read();
  endtask

  // A rise of exactly the threshold holds; one more count switches
  task automatic test_threshold_edge();
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_W'(128), SAMPLE_LOW);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_W'(257), SAMPLE_LOW);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_LOW);
  endtask

  // Unchanged phase, then a jump of both bits each way: no step
  task automatic test_no_step_cases();
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_LOW);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_LOW);
  endtask

  // Other-channel reads (and the unused code) keep the count; the next read clears it
  task automatic test_other_channel();
    send_item(aqd_pkg::OP_SAMPLE, SAMPLE_LOW, SAMPLE_TOP);
    send_item(aqd_pkg::OP_OTHER, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    send_item(OP_SPARE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    send_read();
  endtask

  // Hold off the receiver for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int i;
    wait_drain();
    hold_cycles = 200;
    for (i = 0; i < 12; i++) begin
      if (i == 5) send_read();
      else send_step(1);
    end
    wait_drain();
  endtask

  // Drive the total to both ends and across the wrap; extreme divisors on the reads
  task automatic test_count_wrap();
    int guard;
    configure(1, 200);
    send_read();
    guard = 0;
    while (count_q != 8'h80 && guard < 1000) begin
      send_step(-1);
      guard++;
    end
    send_read();
    guard = 0;
    while (count_q != 8'h7f && guard < 1000) begin
      send_step(1);
      guard++;
    end
    send_read();
    // past +127 the total wraps to -128
    guard = 0;
    while (count_q != 8'h80 && guard < 1000) begin
      send_step(1);
      guard++;
    end
    configure(65535, 200);
    send_read();
  endtask

  // Mostly well-formed rotation with random content; reads, other-channel reads,
  // invalid jumps, dwells and raw noise mixed in
  task automatic test_random_traffic(input int n, input int steps, input int thr,
                                     input int read_pm, input bit quiet);
    int i, r;
    configure(steps, thr);
    no_idle = quiet;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(999);
      if (r < read_pm) begin
        send_read();
      end else if (r < read_pm + 20) begin
        send_item($urandom_range(1) ? aqd_pkg::OP_OTHER : OP_SPARE, SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom));
      end else if (r < read_pm + 100) begin
        send_item(aqd_pkg::OP_SAMPLE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end else if (r < read_pm + 140) begin
        send_toward(~phase_q);
      end else if (r < read_pm + 220) begin
        send_toward(phase_q);
      end else begin
        if ($urandom_range(99) < 3) spin_dir = -spin_dir;
        send_step(spin_dir);
      end
    end
    wait_drain();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = aqd_pkg::OP_SAMPLE;
    in_bus.sample_a = '0;
    in_bus.sample_b = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = aqd_pkg::REG_STEPS;
    cfg_bus.wdata = '0;
    prev_a = '0;
    prev_b = '0;
    phase_q = '0;
    count_q = '0;
    steps_q = STEPS_AFTER_RESET;
    thresh_q = THRESH_AFTER_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_read();
    test_forward_turn();
    test_backward_turn();
    test_threshold_edge();
    test_no_step_cases();
    test_other_channel();
    test_backpressure();
    test_count_wrap();

    test_random_traffic(200, 24, 128, 40, 1'b0);
    test_random_traffic(150, 1, 0, 60, 1'b0);
    test_random_traffic(60, 65535, 4095, 60, 1'b0);
    test_random_traffic(150, 0, 300, 50, 1'b0);
    test_random_traffic(150, 7, $urandom_range(1500, 1), 80, 1'b1);
    for (k = 0; k < 3; k++)
      test_random_traffic(130, $urandom_range(1) ? $urandom_range(400, 1) :
                          $urandom_range(65535, 1), $urandom_range(2000, 0),
                          $urandom_range(100, 5), 1'b0);

    // let any stray result surface before judging
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
